// File: rtl/rlpp_pkg.sv
package rlpp_pkg;

  localparam int FracBits   = 16;
  localparam int MaxPoses   = 1024;
  localparam int TailOffset = 10;
  localparam int CntW       = 11;
  localparam int TailW      = 4;

  localparam logic [2:0] CfgLookahead = 3'd0;
  localparam logic [2:0] CfgSpeedMax  = 3'd1;
  localparam logic [2:0] CfgTurnAcc   = 3'd2;
  localparam logic [2:0] CfgLinAcc    = 3'd3;
  localparam logic [2:0] CfgLinDec    = 3'd4;
  localparam logic [2:0] CfgStepTime  = 3'd5;
  localparam logic [2:0] CfgSpeedFlr  = 3'd6;

  typedef struct packed {
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic               final_pose;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] angular_setpoint;
    logic [30:0]        linear_setpoint;
    logic [9:0]         goal_index;
    logic [30:0]        tail_range;
    logic signed [31:0] cross_track;
  } out_word_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_SQX, ST_SQY, ST_ROOT, ST_UPD,
    ST_DW, ST_DVA, ST_DVD, ST_LL, ST_SEL,
    ST_NUM1, ST_NUM2, ST_DIV, ST_CHK, ST_FIN, ST_OUT
  } state_t;

  // request to the shared multiply unit
  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

endpackage

// File: rtl/rlpp_mul.sv
import rlpp_pkg::*;
module rlpp_mul (
  input  logic        clk,
  input  mul_req_t    req,
  output logic [63:0] prod
);
  // unsigned 64x64 low product, one 16x64 partial per cycle
  logic [63:0] a_r, b_r, acc_r;
  logic [63:0] a_nxt, b_nxt, acc_nxt;
  logic [15:0] dig;
  logic [63:0] part;

  always_comb begin
    dig = a_r[15:0];
    part = 64'(b_r * {48'd0, dig});
    a_nxt = a_r >> 16;
    b_nxt = b_r << 16;
    acc_nxt = acc_r + part;
    if (req.start) begin
      a_nxt = req.a;
      b_nxt = req.b;
      acc_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
    acc_r <= acc_nxt;
  end

  assign prod = acc_r;
endmodule

// File: rtl/rate_limited_pure_pursuit.sv
// Pure-pursuit tracker: each pose, while fewer than MaxPoses are stored, takes two
// products and a 32-step square root, one bit pair per cycle. The final pose adds four
// products and up to three 80-step divisions of a shared divider, each division after
// its own numerator product, before out_valid rises.
// in_ready is low while a word is in work or a result waits at the output.
// rst_n (synchronous) clears set-points, path state and config registers to defaults.
import rlpp_pkg::*;
module rate_limited_pure_pursuit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_word_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_word_t   out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [30:0] cfg_data
);
  logic [24:0] la_r;
  logic [30:0] smax_r, tacc_r, lacc_r, ldec_r, dt_r, sflr_r;

  state_t st_r, st_nxt;
  in_word_t iw_r, iw_nxt;
  logic [63:0] sq_r, sq_nxt;               // x*x, added to y*y for the root radicand
  logic [63:0] rem_r, rem_nxt, res_r, res_nxt, bit_r, bit_nxt;
  logic [31:0] rng_r, rng_nxt;
  logic signed [31:0] pa_r, pa_nxt, pl_r, pl_nxt;
  logic [31:0] bg_r, bg_nxt, bl_r, bl_nxt, am_r, am_nxt, al_r, al_nxt, fr_r, fr_nxt;
  logic [9:0] bi_r, bi_nxt;
  logic [CntW-1:0] pc_r, pc_nxt;
  logic [31:0] rr [TailOffset];
  logic [31:0] rr_q;
  logic rr_we;
  logic [TailW-1:0] rr_wa, tptr_r, tptr_nxt;
  logic [45:0] dw_r, dw_nxt, dva_r, dva_nxt, dvd_r, dvd_nxt;
  logic [63:0] den_r, den_nxt;
  logic signed [33:0] v_r, v_nxt;
  logic [1:0] ph_r, ph_nxt;                // 0 acc, 1 hold, 2 brake
  logic [81:0] dq_r, dq_nxt;               // divider: numerator shifted in
  logic [64:0] dr_r, dr_nxt;
  logic [33:0] q_r, q_nxt;
  logic [6:0] di_r, di_nxt;
  logic [2:0] mc_r, mc_nxt;
  logic ov_r, ov_nxt;
  out_word_t od_r, od_nxt;
  mul_req_t mreq;
  logic [63:0] prod;

  rlpp_mul u_mul (.clk(clk), .req(mreq), .prod(prod));

  logic [31:0] absx, absy, yabs, gap, lx;
  logic signed [34:0] wv, dwd;
  logic signed [47:0] dws, vacc, vdec;
  logic signed [34:0] pa35;
  logic [34:0] adiff, aw, apa;
  logic brk, neg;
  logic [64:0] rtry;
  logic [64:0] drs;
  logic [33:0] qabs;
  logic signed [31:0] wsat;
  logic [33:0] vabs;
  logic [31:0] tail;

  assign in_ready = (st_r == ST_IDLE) && !ov_r;
  assign out_valid = ov_r;
  assign out_data = od_r;

  always_ff @(posedge clk) begin
    if (rr_we) rr[rr_wa] <= rng_r;
    rr_q <= rr[tptr_r];
  end

  always_comb begin
    absx = iw_r.pose_x[31] ? 32'(-iw_r.pose_x) : iw_r.pose_x;
    absy = iw_r.pose_y[31] ? 32'(-iw_r.pose_y) : iw_r.pose_y;
    yabs = bl_r[31] ? 32'(-bl_r) : bl_r;
    lx = (la_r == '0) ? 32'd1 : {7'd0, la_r};
    // goal search uses the raw look-ahead, zero included
    gap = (res_r[31:0] >= {7'd0, la_r}) ? res_r[31:0] - {7'd0, la_r}
                                         : {7'd0, la_r} - res_r[31:0];
    rtry = {1'b0, res_r} + {1'b0, bit_r};
    drs = {dr_r[63:0], dq_r[81]};
    vabs = v_r[33] ? 34'(-v_r) : 34'(v_r);
    neg = (bl_r[31] == v_r[33]);
    qabs = q_r;
    wv = neg ? -$signed({1'b0, qabs}) : $signed({1'b0, qabs});
    if (wv > 35'sd2147483647) wsat = 32'h7fffffff;
    else if (wv < -35'sd2147483648) wsat = 32'h80000000;
    else wsat = 32'(wv);
    pa35 = 35'(pa_r);
    dwd = 35'(wsat) - pa35;
    adiff = dwd[34] ? 35'(-dwd) : 35'(dwd);
    aw = wsat[31] ? 35'(-35'(wsat)) : 35'(wsat);
    apa = pa_r[31] ? 35'(-pa35) : 35'(pa35);
    brk = ({11'd0, adiff} > dw_r) && (aw > apa);
    dws = 48'sd0;
    vacc = 48'(pl_r) + $signed({2'b0, dva_r});
    vdec = 48'(pl_r) - $signed({2'b0, dvd_r});
    tail = (pc_r >= CntW'(TailOffset)) ? rr_q : fr_r;

    st_nxt = st_r; iw_nxt = iw_r; sq_nxt = sq_r; rem_nxt = rem_r; res_nxt = res_r;
    bit_nxt = bit_r; rng_nxt = rng_r; pa_nxt = pa_r; pl_nxt = pl_r; bg_nxt = bg_r;
    bl_nxt = bl_r; am_nxt = am_r; al_nxt = al_r; fr_nxt = fr_r; bi_nxt = bi_r;
    pc_nxt = pc_r; tptr_nxt = tptr_r; dw_nxt = dw_r; dva_nxt = dva_r;
    dvd_nxt = dvd_r; den_nxt = den_r; v_nxt = v_r; ph_nxt = ph_r;
    dq_nxt = dq_r; dr_nxt = dr_r; q_nxt = q_r; di_nxt = di_r; mc_nxt = mc_r + 3'd1;
    ov_nxt = ov_r; od_nxt = od_r; rr_we = 1'b0; rr_wa = tptr_r;
    mreq = '0;
    if (ov_r && out_ready) ov_nxt = 1'b0;

    case (st_r)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          iw_nxt = in_data;
          if (pc_r < CntW'(MaxPoses)) st_nxt = ST_SQX;
          else if (in_data.final_pose) st_nxt = ST_DW;
          mc_nxt = '0;
        end
      end
      ST_SQX: begin
        mreq.start = (mc_r == 3'd0);
        mreq.a = {32'd0, absx}; mreq.b = {32'd0, absx};
        if (mc_r == 3'd4) begin
          sq_nxt = prod; mc_nxt = '0; st_nxt = ST_SQY;
        end
      end
      ST_SQY: begin
        mreq.start = (mc_r == 3'd0);
        mreq.a = {32'd0, absy}; mreq.b = {32'd0, absy};
        if (mc_r == 3'd4) begin
          rem_nxt = sq_r + prod; res_nxt = '0; bit_nxt = 64'd1 << 62;
          st_nxt = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if ({1'b0, rem_r} >= rtry) begin
          rem_nxt = rem_r - rtry[63:0]; res_nxt = (res_r >> 1) + bit_r;
        end else res_nxt = res_r >> 1;
        bit_nxt = bit_r >> 2;
        if (bit_r[0]) st_nxt = ST_UPD;
      end
      ST_UPD: begin
        rng_nxt = res_r[31:0];
        // range latched; bookkeeping in this state uses res_r directly
        if (gap < bg_r) begin
          bg_nxt = gap;
          bi_nxt = pc_r[9:0]; bl_nxt = iw_r.pose_y;
        end
        if (!iw_r.pose_x[31] && iw_r.pose_x < am_r) begin
          am_nxt = iw_r.pose_x; al_nxt = iw_r.pose_y;
        end
        if (pc_r == '0) fr_nxt = res_r[31:0];
        pc_nxt = pc_r + 1'b1;
        tptr_nxt = (tptr_r == TailW'(TailOffset - 1)) ? '0 : tptr_r + 1'b1;
        st_nxt = iw_r.final_pose ? ST_DW : ST_IDLE;
        mc_nxt = '0;
      end
      ST_DW: begin
        mreq.start = (mc_r == 3'd0);
        mreq.a = {33'd0, tacc_r}; mreq.b = {33'd0, dt_r};
        if (mc_r == 3'd4) begin
          dw_nxt = prod[61:16]; mc_nxt = '0; st_nxt = ST_DVA;
        end
      end
      ST_DVA: begin
        mreq.start = (mc_r == 3'd0);
        mreq.a = {33'd0, lacc_r}; mreq.b = {33'd0, dt_r};
        if (mc_r == 3'd4) begin
          dva_nxt = prod[61:16]; mc_nxt = '0; st_nxt = ST_DVD;
        end
      end
      ST_DVD: begin
        mreq.start = (mc_r == 3'd0);
        mreq.a = {33'd0, ldec_r}; mreq.b = {33'd0, dt_r};
        if (mc_r == 3'd4) begin
          dvd_nxt = prod[61:16]; mc_nxt = '0; st_nxt = ST_LL;
        end
      end
      ST_LL: begin
        mreq.start = (mc_r == 3'd0);
        mreq.a = {32'd0, lx}; mreq.b = {32'd0, lx};
        if (mc_r == 3'd4) begin
          den_nxt = prod; ph_nxt = 2'd0;
          if (vacc > $signed({17'd0, smax_r})) v_nxt = {3'd0, smax_r};
          else v_nxt = 34'(vacc);
          mc_nxt = '0; st_nxt = ST_NUM1;
        end
      end
      ST_SEL: begin
        st_nxt = ST_NUM1; mc_nxt = '0;
      end
      ST_NUM1: begin
        mreq.start = (mc_r == 3'd0);
        mreq.a = {31'd0, yabs, 1'b0}; mreq.b = {30'd0, vabs};
        if (mc_r == 3'd4) begin
          dq_nxt = {prod, 18'd0}; dr_nxt = '0; q_nxt = '0; di_nxt = '0;
          st_nxt = ST_DIV;
        end
      end
      ST_NUM2: st_nxt = ST_DIV;
      ST_DIV: begin
        // restoring divide of (num<<16)/den, one quotient bit per cycle
        dq_nxt = dq_r << 1;
        if (drs >= {1'b0, den_r}) begin
          dr_nxt = drs - {1'b0, den_r};
          q_nxt = q_r[33] ? q_r : {q_r[32:0], 1'b1};
        end else begin
          dr_nxt = drs;
          q_nxt = q_r[33] ? q_r : {q_r[32:0], 1'b0};
        end
        if (q_r[33]) q_nxt = 34'h200000000;
        di_nxt = di_r + 7'd1;
        if (di_r == 7'd79) st_nxt = ST_CHK;
      end
      ST_CHK: begin
        st_nxt = ST_FIN;
        if (ph_r != 2'd2 && brk) begin
          st_nxt = ST_SEL;
          if (ph_r == 2'd0) begin
            v_nxt = 34'(pl_r); ph_nxt = 2'd1;
          end else begin
            ph_nxt = 2'd2;
            if (vdec < -48'sd2147483648) v_nxt = -34'sd2147483648;
            else v_nxt = 34'(vdec);
          end
        end
      end
      ST_FIN: begin
        pa_nxt = wsat;
        if (ph_r == 2'd2 && {11'd0, adiff} > dw_r) begin
          if (!dwd[34] && dwd != '0 && aw > apa) dws = 48'(pa_r) + $signed({2'b0, dw_r});
          else dws = 48'(pa_r) - $signed({2'b0, dw_r});
          if (dws > 48'sd2147483647) pa_nxt = 32'h7fffffff;
          else if (dws < -48'sd2147483648) pa_nxt = 32'h80000000;
          else pa_nxt = 32'(dws);
        end
        pl_nxt = (v_r < $signed({3'd0, sflr_r})) ? 32'(sflr_r) : 32'(v_r);
        st_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!ov_r) begin
          od_nxt.angular_setpoint = pa_r;
          od_nxt.linear_setpoint = pl_r[30:0];
          od_nxt.goal_index = bi_r;
          od_nxt.tail_range = tail[31] ? 31'h7fffffff : tail[30:0];
          od_nxt.cross_track = al_r;
          ov_nxt = 1'b1;
          bg_nxt = '1; bi_nxt = '0; bl_nxt = '0; pc_nxt = '0; am_nxt = '1;
          al_nxt = '0; fr_nxt = '0; tptr_nxt = '0;
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
    if (st_r == ST_UPD) begin
      rr_we = 1'b1; rr_wa = tptr_r;
    end
  end

  // range register loads at end of root; write store in UPD with rng_r
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; ov_r <= 1'b0; pa_r <= '0; pl_r <= '0;
      bg_r <= '1; bi_r <= '0; bl_r <= '0; pc_r <= '0; am_r <= '1; al_r <= '0;
      fr_r <= '0; tptr_r <= '0;
      la_r <= 25'd131072; smax_r <= 31'd196608; tacc_r <= 31'd26214;
      lacc_r <= 31'd34079; ldec_r <= 31'd131072; dt_r <= 31'd1311;
      sflr_r <= 31'd32768;
    end else begin
      st_r <= st_nxt; ov_r <= ov_nxt; pa_r <= pa_nxt; pl_r <= pl_nxt;
      bg_r <= bg_nxt; bi_r <= bi_nxt; bl_r <= bl_nxt; pc_r <= pc_nxt;
      am_r <= am_nxt; al_r <= al_nxt; fr_r <= fr_nxt; tptr_r <= tptr_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CfgLookahead: la_r <= cfg_data[24:0];
          CfgSpeedMax:  smax_r <= cfg_data;
          CfgTurnAcc:   tacc_r <= cfg_data;
          CfgLinAcc:    lacc_r <= cfg_data;
          CfgLinDec:    ldec_r <= cfg_data;
          CfgStepTime:  dt_r <= cfg_data;
          CfgSpeedFlr:  sflr_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    iw_r <= iw_nxt; sq_r <= sq_nxt; rem_r <= rem_nxt; res_r <= res_nxt;
    bit_r <= bit_nxt; rng_r <= (st_r == ST_ROOT) ? res_nxt[31:0] : rng_nxt;
    dw_r <= dw_nxt; dva_r <= dva_nxt; dvd_r <= dvd_nxt; den_r <= den_nxt;
    v_r <= v_nxt; ph_r <= ph_nxt; dq_r <= dq_nxt;
    dr_r <= dr_nxt; q_r <= q_nxt; di_r <= di_nxt; mc_r <= mc_nxt; od_r <= od_nxt;
  end
endmodule
